FILE: rtl/srpd_pkg.sv
package srpd_pkg;

   // Field widths
   localparam int SPEED_W   = 11;
   localparam int LOOK_W    = 8;
   localparam int ELAPSED_W = 10;
   localparam int GEAR_W    = 4;
   localparam int BASE_W    = 8;
   localparam int GAIN_W    = 10;
   localparam int DUTY_W    = 14;
   localparam int TARGET_W  = 9;
   localparam int DECEL_W   = 8;
   localparam int ERR_W     = 12;   // target minus measured speed
   localparam int DERR_W    = 13;   // change of error
   localparam int PROD_W    = 23;   // error times gain
   localparam int ACCUM_W   = 15;   // drive accumulator
   localparam int SUM_W     = 25;   // accumulator plus both products
   localparam int GOAL_W    = 10;   // base speed plus look-ahead term

   // CSR map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_GEAR        = 2'd0;
   localparam logic [1:0] REG_BASE_SPEED  = 2'd1;
   localparam logic [1:0] REG_ERROR_GAIN  = 2'd2;
   localparam logic [1:0] REG_CHANGE_GAIN = 2'd3;

   // CSR reset values
   localparam logic [GEAR_W-1:0] GEAR_RESET        = 4'd1;
   localparam logic [BASE_W-1:0] BASE_SPEED_RESET  = 8'd0;
   localparam logic [GAIN_W-1:0] ERROR_GAIN_RESET  = 10'd50;
   localparam logic [GAIN_W-1:0] CHANGE_GAIN_RESET = 10'd130;

   // Gear codes with special targets
   localparam logic [GEAR_W-1:0] GEAR_ZERO  = 4'd0;
   localparam logic [GEAR_W-1:0] GEAR_ONE   = 4'd1;
   localparam logic [GEAR_W-1:0] GEAR_TWO   = 4'd2;
   localparam logic [GEAR_W-1:0] GEAR_EIGHT = 4'd8;
   localparam logic [GEAR_W-1:0] GEAR_NINE  = 4'd9;

   // Fixed targets and thresholds
   localparam logic [TARGET_W-1:0]  TARGET_RESET    = 9'd42;
   localparam logic [TARGET_W-1:0]  TARGET_MAX      = 9'd511;
   localparam logic [TARGET_W-1:0]  TGT_GEAR_ZERO   = 9'd70;
   localparam logic [TARGET_W-1:0]  TGT_RAMP_START  = 9'd67;
   localparam logic [TARGET_W-1:0]  TGT_TURN_TWO    = 9'd55;
   localparam logic [TARGET_W-1:0]  TGT_NINE        = 9'd65;
   localparam logic [TARGET_W-1:0]  TGT_DEFAULT     = 9'd60;
   localparam logic [ELAPSED_W-1:0] RAMP_HOLD_TICKS = 10'd50;
   localparam logic [DECEL_W-1:0]   DECEL_EARLY     = 8'd12;
   localparam logic [DECEL_W-1:0]   DECEL_MAX       = 8'd255;

   // look/10 as (look * 205) >> 11, exact for 8-bit values
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   typedef struct packed {
      logic [GEAR_W-1:0] gear;
      logic [BASE_W-1:0] base_speed;
      logic [GAIN_W-1:0] error_gain;
      logic [GAIN_W-1:0] change_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] measured_speed;
      logic [LOOK_W-1:0]         look_ahead;
      logic                      on_ramp;
      logic [ELAPSED_W-1:0]      ramp_elapsed;
      logic                      in_turn;
      logic                      decel_restart;
   } tick_type;

endpackage

FILE: rtl/srpd_req_if.sv
interface srpd_req_if import srpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] measured_speed;
   logic [LOOK_W-1:0]         look_ahead;
   logic                      on_ramp;
   logic [ELAPSED_W-1:0]      ramp_elapsed;
   logic                      in_turn;
   logic                      decel_restart;

   modport source (
      output valid, measured_speed, look_ahead, on_ramp, ramp_elapsed, in_turn,
             decel_restart,
      input  ready
   );
   modport sink (
      input  valid, measured_speed, look_ahead, on_ramp, ramp_elapsed, in_turn,
             decel_restart,
      output ready
   );
endinterface

FILE: rtl/srpd_rsp_if.sv
interface srpd_rsp_if import srpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DUTY_W-1:0]   forward_duty;
   logic [DUTY_W-1:0]   reverse_duty;
   logic [TARGET_W-1:0] target_now;

   modport source (
      output valid, forward_duty, reverse_duty, target_now,
      input  ready
   );
   modport sink (
      input  valid, forward_duty, reverse_duty, target_now,
      output ready
   );
endinterface

FILE: rtl/srpd_target.sv
// Next target speed and deceleration tick count for one request
module srpd_target import srpd_pkg::*; (
   input  cfg_type             cfg,
   input  tick_type            tick,
   input  logic [TARGET_W-1:0] target_cur,
   input  logic [DECEL_W-1:0]  decel_cur,
   output logic [TARGET_W-1:0] target_next,
   output logic [DECEL_W-1:0]  decel_next
);

   // One step toward a goal; equal to goal still rises, saturates at both ends
   function automatic logic [TARGET_W-1:0] step_toward(input logic [TARGET_W-1:0] t,
                                                       input logic [GOAL_W-1:0] goal);
      logic [TARGET_W-1:0] r;
      r = t;
      if (GOAL_W'(t) <= goal) begin
         if (t != TARGET_MAX) r = t + 1'b1;
      end else begin
         if (t != '0) r = t - 1'b1;
      end
      return r;
   endfunction

   logic [15:0]         look_prod;
   logic [GOAL_W-1:0]   goal_quarter;
   logic [GOAL_W-1:0]   goal_tenth;
   logic [DECEL_W-1:0]  decel_eff;
   logic                early;
   logic [TARGET_W-1:0] t_ramp;
   logic [TARGET_W-1:0] t_nine;
   logic [TARGET_W-1:0] t_over;

   // Goals: base + look/4 and base + look/10
   assign look_prod    = 16'(tick.look_ahead) * 16'(DIV10_MUL);
   assign goal_quarter = GOAL_W'(cfg.base_speed) + GOAL_W'(tick.look_ahead[LOOK_W-1:2]);
   assign goal_tenth   = GOAL_W'(cfg.base_speed) + GOAL_W'(look_prod[15:DIV10_SHIFT]);

   // Restart clears the counter before this tick
   assign decel_eff  = tick.decel_restart ? '0 : decel_cur;
   assign early      = decel_eff < DECEL_EARLY;
   assign decel_next = (decel_eff == DECEL_MAX) ? DECEL_MAX : decel_eff + 1'b1;

   // Ramp steps
   assign t_ramp = step_toward(target_cur, goal_quarter);
   assign t_nine = (cfg.gear == GEAR_NINE) ? step_toward(t_ramp, goal_tenth) : t_ramp;

   // Overrides, later ones win
   always_comb begin
      t_over = t_nine;
      if (cfg.gear == GEAR_ZERO) t_over = TGT_GEAR_ZERO;
      if (tick.on_ramp && (tick.ramp_elapsed < RAMP_HOLD_TICKS)) t_over = TGT_RAMP_START;
      if (tick.in_turn) begin
         if (cfg.gear == GEAR_TWO) begin
            t_over = TGT_TURN_TWO;
         end else if (cfg.gear == GEAR_NINE) begin
            t_over = TGT_NINE;
         end else if (cfg.gear != GEAR_ONE) begin
            t_over = TGT_DEFAULT;
         end
      end
      if (early) begin
         if ((cfg.gear == GEAR_ZERO) || (cfg.gear == GEAR_EIGHT)) begin
            t_over = TGT_DEFAULT;
         end else if (cfg.gear == GEAR_NINE) begin
            t_over = TGT_NINE;
         end
      end
   end

   assign target_next = t_over;

endmodule

FILE: rtl/speed_ramp_incremental_pi_drive.sv
// Speed ramp with incremental PI motor drive. Each request is one control tick;
// the block returns one result per request: forward and reverse PWM duty from
// the clamped drive accumulator, plus the target speed used on that tick. The
// pipeline takes one request per cycle unless stalled by the result side, and
// passes it through the input register, target stage, gain multiply stage and
// accumulate/clamp stage into the output register. Each state loop - target
// and deceleration counter, last error, drive accumulator - closes inside its
// own stage, so consecutive ticks flow without gaps. Backpressure from the
// result side stalls only the stages that are full. CSRs (byte address 4*i):
// gear, base_speed, error_gain, change_gain; write them only while idle.
module speed_ramp_incremental_pi_drive import srpd_pkg::*; #(
   parameter int PWM_LIMIT = 10000
) (
   input  logic                  clock,
   input  logic                  reset,
   srpd_req_if.sink              req_chan,
   srpd_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic signed [SUM_W-1:0] LIMIT_POS = SUM_W'(PWM_LIMIT);
   localparam logic signed [SUM_W-1:0] LIMIT_NEG = -SUM_W'(PWM_LIMIT);

   // ---------------- CSRs ----------------
   cfg_type    cfg_ff, cfg_in;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_GEAR:        cfg_in.gear        = csr_pwdata[GEAR_W-1:0];
            REG_BASE_SPEED:  cfg_in.base_speed  = csr_pwdata[BASE_W-1:0];
            REG_ERROR_GAIN:  cfg_in.error_gain  = csr_pwdata[GAIN_W-1:0];
            REG_CHANGE_GAIN: cfg_in.change_gain = csr_pwdata[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gear: GEAR_RESET, base_speed: BASE_SPEED_RESET,
                     error_gain: ERROR_GAIN_RESET, change_gain: CHANGE_GAIN_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Readback
   always_comb begin
      unique case (csr_idx)
         REG_GEAR:        csr_prdata = CSR_DATA_W'(cfg_ff.gear);
         REG_BASE_SPEED:  csr_prdata = CSR_DATA_W'(cfg_ff.base_speed);
         REG_ERROR_GAIN:  csr_prdata = CSR_DATA_W'(cfg_ff.error_gain);
         REG_CHANGE_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.change_gain);
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic xfer1, xfer2, xfer3, xfer4;

   assign rdy4  = !v4_ff || rsp_chan.ready;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign xfer1 = req_chan.valid && rdy1;
   assign xfer2 = v1_ff && rdy2;
   assign xfer3 = v2_ff && rdy3;
   assign xfer4 = v3_ff && rdy4;

   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_chan.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   tick_type tick_ff, tick_in;

   assign tick_in = '{measured_speed: req_chan.measured_speed,
                      look_ahead:     req_chan.look_ahead,
                      on_ramp:        req_chan.on_ramp,
                      ramp_elapsed:   req_chan.ramp_elapsed,
                      in_turn:        req_chan.in_turn,
                      decel_restart:  req_chan.decel_restart};

   always_ff @(posedge clock) begin
      if (xfer1) tick_ff <= tick_in;
   end

   // ---------------- stage 2: target speed and error ----------------
   logic [TARGET_W-1:0]     target_ff, target_in;
   logic [DECEL_W-1:0]      decel_ff, decel_in;
   logic [TARGET_W-1:0]     tgt2_ff;
   logic signed [ERR_W-1:0] err2_ff, err2_in;

   srpd_target u_target (
      .cfg         (cfg_ff),
      .tick        (tick_ff),
      .target_cur  (target_ff),
      .decel_cur   (decel_ff),
      .target_next (target_in),
      .decel_next  (decel_in)
   );

   assign err2_in = signed'(ERR_W'(target_in)) - ERR_W'(tick_ff.measured_speed);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         decel_ff  <= DECEL_MAX;
      end else if (xfer2) begin
         target_ff <= target_in;
         decel_ff  <= decel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer2) begin
         tgt2_ff <= target_in;
         err2_ff <= err2_in;
      end
   end

   // ---------------- stage 3: gain products ----------------
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [DERR_W-1:0] derr;
   logic signed [PROD_W-1:0] err_x, derr_x, eg_x, cg_x;
   logic signed [PROD_W-1:0] perr3_ff, perr3_in, pchg3_ff, pchg3_in;
   logic [TARGET_W-1:0]      tgt3_ff;

   assign derr     = DERR_W'(err2_ff) - DERR_W'(last_err_ff);
   assign err_x    = PROD_W'(err2_ff);
   assign derr_x   = PROD_W'(derr);
   assign eg_x     = signed'(PROD_W'(cfg_ff.error_gain));
   assign cg_x     = signed'(PROD_W'(cfg_ff.change_gain));
   assign perr3_in = err_x * eg_x;
   assign pchg3_in = derr_x * cg_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
      end else if (xfer3) begin
         last_err_ff <= err2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer3) begin
         perr3_ff <= perr3_in;
         pchg3_ff <= pchg3_in;
         tgt3_ff  <= tgt2_ff;
      end
   end

   // ---------------- stage 4: accumulate, clamp, split ----------------
   logic signed [ACCUM_W-1:0] accum_ff, accum_in;
   logic signed [ACCUM_W-1:0] accum_neg;
   logic signed [SUM_W-1:0]   sum;
   logic [DUTY_W-1:0]         fwd_ff, fwd_in, rev_ff, rev_in;
   logic [TARGET_W-1:0]       tgt4_ff;

   assign sum = SUM_W'(accum_ff) + SUM_W'(perr3_ff) + SUM_W'(pchg3_ff);

   always_comb begin
      priority if (sum > LIMIT_POS) begin
         accum_in = ACCUM_W'(LIMIT_POS);
      end else if (sum < LIMIT_NEG) begin
         accum_in = ACCUM_W'(LIMIT_NEG);
      end else begin
         accum_in = sum[ACCUM_W-1:0];
      end
   end

   // Positive drive goes forward, zero or negative goes reverse
   assign accum_neg = -accum_in;
   assign fwd_in = (accum_in > 0) ? accum_in[DUTY_W-1:0] : '0;
   assign rev_in = (accum_in > 0) ? '0 : accum_neg[DUTY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else if (xfer4) begin
         accum_ff <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer4) begin
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         tgt4_ff <= tgt3_ff;
      end
   end

   assign rsp_chan.valid        = v4_ff;
   assign rsp_chan.forward_duty = fwd_ff;
   assign rsp_chan.reverse_duty = rev_ff;
   assign rsp_chan.target_now   = tgt4_ff;

endmodule

FILE: tb/speed_ramp_incremental_pi_drive_test.sv
module speed_ramp_incremental_pi_drive_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srpd_pkg::*;

   localparam int DRIVE_LIMIT   = 10000;
   localparam int TAIL_CYCLES   = 12;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_TICKS   = 93;
   localparam int REPORT_MAX    = 10;

   // one result: duty split plus the target used
   typedef struct packed {
      logic [DUTY_W-1:0]   fwd;
      logic [DUTY_W-1:0]   rev;
      logic [TARGET_W-1:0] target;
   } drive_out_type;

   // one row of the directed stimulus
   typedef struct {
      cfg_type       setting;
      tick_type      tick;
      bit            typed;
      drive_out_type want;
   } plan_row_type;

   localparam cfg_type CFG_RESET =
      '{GEAR_RESET, BASE_SPEED_RESET, ERROR_GAIN_RESET, CHANGE_GAIN_RESET};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   srpd_req_if req_if ();
   srpd_rsp_if rsp_if ();

   speed_ramp_incremental_pi_drive #(.PWM_LIMIT(DRIVE_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mirror of the block's registers and loop state
   cfg_type                   cfg_m;
   logic [TARGET_W-1:0]       tgt_speed;
   logic signed [ERR_W-1:0]   prev_err;
   logic signed [ACCUM_W-1:0] drive_acc;
   logic [DECEL_W-1:0]        decel_cnt;

   drive_out_type duty_expect[$];
   plan_row_type  tick_plan[$];

   int gap_pct    = 0;
   int stall_pct  = 0;
   int n_requests = 0;
   int n_results  = 0;
   int n_writes   = 0;
   int n_settings = 0;
   int n_mismatch = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still pending", duty_expect.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      n_mismatch++;
      if (n_mismatch <= REPORT_MAX)
         $display("[%0t] MISMATCH %s (result %0d): expected %0d, got %0d",
                  $realtime, what, n_results, want, got);
   endfunction

   // one unit step of the target toward a goal, saturating at the field bounds
   function automatic int approach(input int t, input int goal);
      if (t <= goal) return (t < int'(TARGET_MAX)) ? t + 1 : t;
      return (t > 0) ? t - 1 : t;
   endfunction

   // ramp target, overrides, incremental PI update and duty split for one tick
   function automatic void advance_drive(input tick_type tk, output drive_out_type res);
      int     tgt;
      int     err;
      int     derr;
      longint sum;
      if (tk.decel_restart) decel_cnt = '0;
      tgt = approach(int'(tgt_speed), int'(cfg_m.base_speed) + int'(tk.look_ahead) / 4);
      if (cfg_m.gear == GEAR_NINE)
         tgt = approach(tgt, int'(cfg_m.base_speed) + int'(tk.look_ahead) / 10);
      if (cfg_m.gear == GEAR_ZERO) tgt = int'(TGT_GEAR_ZERO);
      if (tk.on_ramp && tk.ramp_elapsed < RAMP_HOLD_TICKS) tgt = int'(TGT_RAMP_START);
      if (tk.in_turn) begin
         case (cfg_m.gear)
            GEAR_ONE: ;
            GEAR_TWO: tgt = int'(TGT_TURN_TWO);
            GEAR_NINE: tgt = int'(TGT_NINE);
            default: tgt = int'(TGT_DEFAULT);
         endcase
      end
      // early deceleration after a counter restart
      if (decel_cnt < DECEL_EARLY) begin
         case (cfg_m.gear)
            GEAR_ZERO, GEAR_EIGHT: tgt = int'(TGT_DEFAULT);
            GEAR_NINE: tgt = int'(TGT_NINE);
            default: ;
         endcase
      end
      tgt_speed = TARGET_W'(tgt);

      err  = tgt - int'($signed(tk.measured_speed));
      derr = err - int'(prev_err);
      prev_err = ERR_W'(err);
      sum = longint'(drive_acc) + longint'(err) * longint'(cfg_m.error_gain)
          + longint'(derr) * longint'(cfg_m.change_gain);
      if (sum > longint'(DRIVE_LIMIT)) sum = longint'(DRIVE_LIMIT);
      if (sum < -longint'(DRIVE_LIMIT)) sum = -longint'(DRIVE_LIMIT);
      drive_acc = ACCUM_W'(sum);

      if (sum > 0) begin
         res.fwd = DUTY_W'(sum);
         res.rev = '0;
      end else begin
         res.fwd = '0;
         res.rev = DUTY_W'(-sum);
      end
      res.target = tgt_speed;
      if (decel_cnt != DECEL_MAX) decel_cnt++;
   endfunction

   function automatic void check_duty(input drive_out_type got);
      drive_out_type want;
      n_results++;
      if (duty_expect.size() == 0) begin
         flag_mismatch("result with no pending request", '0, 32'(got.target));
         return;
      end
      want = duty_expect.pop_front();
      if (got.fwd !== want.fwd)
         flag_mismatch("forward_duty", 32'(want.fwd), 32'(got.fwd));
      if (got.rev !== want.rev)
         flag_mismatch("reverse_duty", 32'(want.rev), 32'(got.rev));
      if (got.target !== want.target)
         flag_mismatch("target_now", 32'(want.target), 32'(got.target));
   endfunction

   function automatic cfg_type mk_cfg(input logic [GEAR_W-1:0] g, input int b,
                                      input int e, input int c);
      cfg_type r;
      r.gear        = g;
      r.base_speed  = BASE_W'(b);
      r.error_gain  = GAIN_W'(e);
      r.change_gain = GAIN_W'(c);
      return r;
   endfunction

   function automatic tick_type mk_tick(input int speed, input int look, input bit ramp,
                                        input int elapsed, input bit turn, input bit restart);
      tick_type r;
      r.measured_speed = SPEED_W'(speed);
      r.look_ahead     = LOOK_W'(look);
      r.on_ramp        = ramp;
      r.ramp_elapsed   = ELAPSED_W'(elapsed);
      r.in_turn        = turn;
      r.decel_restart  = restart;
      return r;
   endfunction

   function automatic void add_row(input cfg_type c, input tick_type tk,
                                   input bit typed = 1'b0, input drive_out_type want = '0);
      plan_row_type r;
      r.setting = c;
      r.tick    = tk;
      r.typed   = typed;
      r.want    = want;
      tick_plan.push_back(r);
   endfunction

   // directed rows: extremes, every override, clamps, zero gains
   function automatic void build_plan();
      cfg_type g0;
      cfg_type g2;
      cfg_type g9;
      cfg_type g8;
      cfg_type hot;
      cfg_type dead;
      g0   = mk_cfg(GEAR_ZERO, 0, 50, 130);
      g2   = mk_cfg(GEAR_TWO, 0, 50, 130);
      g9   = mk_cfg(GEAR_NINE, 0, 50, 130);
      g8   = mk_cfg(GEAR_EIGHT, 0, 50, 130);
      hot  = mk_cfg(GEAR_ONE, 255, 1023, 1023);
      dead = mk_cfg(GEAR_ONE, 255, 0, 0);
      // fresh after reset: target falls from 42 toward a zero goal
      add_row(CFG_RESET, mk_tick(0, 0, 0, 0, 0, 0), 1'b1, '{14'd7380, 14'd0, 9'd41});
      add_row(CFG_RESET, mk_tick(-1024, 0, 0, 0, 0, 0), 1'b1, '{14'd10000, 14'd0, 9'd40});
      add_row(CFG_RESET, mk_tick(1023, 0, 0, 0, 0, 0), 1'b1, '{14'd0, 14'd10000, 9'd39});
      add_row(CFG_RESET, mk_tick(40, 255, 0, 0, 0, 0));
      // ramp start window edges
      add_row(CFG_RESET, mk_tick(45, 128, 1, 0, 0, 0));
      add_row(CFG_RESET, mk_tick(67, 128, 1, 49, 0, 0));
      add_row(CFG_RESET, mk_tick(67, 128, 1, 50, 0, 0));
      add_row(CFG_RESET, mk_tick(60, 128, 1, 1023, 1, 0));
      // per-gear forced targets
      add_row(g0, mk_tick(70, 200, 0, 0, 0, 0));
      add_row(g0, mk_tick(60, 200, 0, 0, 1, 0));
      add_row(g0, mk_tick(60, 200, 0, 0, 0, 1));
      add_row(g2, mk_tick(55, 100, 0, 0, 1, 0));
      add_row(g9, mk_tick(30, 255, 0, 0, 0, 0));
      add_row(g9, mk_tick(65, 255, 0, 0, 1, 0));
      add_row(g9, mk_tick(65, 255, 0, 0, 0, 1));
      add_row(g8, mk_tick(60, 255, 0, 0, 0, 1));
      add_row(g8, mk_tick(60, 255, 0, 0, 0, 0));
      add_row(mk_cfg(4'd15, 0, 50, 130), mk_tick(60, 50, 0, 0, 1, 0));
      add_row(mk_cfg(4'd3, 0, 50, 130), mk_tick(40, 50, 0, 0, 0, 1));
      // accumulator clamp both ways, then gains at zero
      add_row(hot, mk_tick(-1024, 255, 0, 0, 0, 0));
      add_row(hot, mk_tick(1023, 255, 0, 0, 0, 0));
      add_row(dead, mk_tick(-1024, 255, 0, 1023, 0, 0));
      add_row(dead, mk_tick(1023, 0, 1, 1023, 1, 0));
   endfunction

   // setting for one random phase; the first four pin the reset values and register extremes
   function automatic cfg_type phase_cfg(input int ph);
      cfg_type           c;
      logic [GEAR_W-1:0] hot_gear[5];
      hot_gear = '{GEAR_ZERO, GEAR_ONE, GEAR_TWO, GEAR_EIGHT, GEAR_NINE};
      case (ph)
         0: c = CFG_RESET;
         1: c = mk_cfg(GEAR_ZERO, 255, 1023, 1023);
         2: c = mk_cfg(GEAR_NINE, 0, 0, 0);
         3: c = mk_cfg(4'd15, 255, 1, 1023);
         default: begin
            c.gear        = $urandom_range(1) ? hot_gear[$urandom_range(4)] : GEAR_W'($urandom);
            c.base_speed  = BASE_W'($urandom);
            c.error_gain  = $urandom_range(1) ? GAIN_W'($urandom_range(120)) : GAIN_W'($urandom);
            c.change_gain = $urandom_range(1) ? GAIN_W'($urandom_range(200)) : GAIN_W'($urandom);
         end
      endcase
      return c;
   endfunction

   // random tick: speed mostly near the current target, rare counter restarts
   function automatic tick_type rand_tick();
      tick_type tk;
      int       s;
      if ($urandom_range(2) != 0) begin
         s = int'(tgt_speed) + int'($urandom_range(48)) - 24;
         tk.measured_speed = SPEED_W'(s);
      end else begin
         tk.measured_speed = SPEED_W'($urandom);
      end
      tk.look_ahead    = LOOK_W'($urandom);
      tk.on_ramp       = ($urandom_range(3) == 0);
      tk.ramp_elapsed  = $urandom_range(1) ? ELAPSED_W'($urandom_range(60))
                                           : ELAPSED_W'($urandom);
      tk.in_turn       = ($urandom_range(4) == 0);
      tk.decel_restart = ($urandom_range(19) == 0);
      return tk;
   endfunction

   // APB write followed by a readback of the same register
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] kept;
      case (idx)
         REG_GEAR: begin
            cfg_m.gear = data[GEAR_W-1:0];
            kept = CSR_DATA_W'(cfg_m.gear);
         end
         REG_BASE_SPEED: begin
            cfg_m.base_speed = data[BASE_W-1:0];
            kept = CSR_DATA_W'(cfg_m.base_speed);
         end
         REG_ERROR_GAIN: begin
            cfg_m.error_gain = data[GAIN_W-1:0];
            kept = CSR_DATA_W'(cfg_m.error_gain);
         end
         default: begin
            cfg_m.change_gain = data[GAIN_W-1:0];
            kept = CSR_DATA_W'(cfg_m.change_gain);
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      // back-to-back read of the same address
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== kept) flag_mismatch("register readback", kept, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // bus returns to idle before the next transfer
      @(posedge clock);
      n_writes++;
   endtask

   // unused upper bits carry noise; the block must mask them
   task automatic load_cfg(input cfg_type c);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[GEAR_W-1:0] = c.gear;
      csr_write(REG_GEAR, word);
      word = $urandom;
      word[BASE_W-1:0] = c.base_speed;
      csr_write(REG_BASE_SPEED, word);
      word = $urandom;
      word[GAIN_W-1:0] = c.error_gain;
      csr_write(REG_ERROR_GAIN, word);
      word = $urandom;
      word[GAIN_W-1:0] = c.change_gain;
      csr_write(REG_CHANGE_GAIN, word);
      n_settings++;
   endtask

   // stop sending and wait until every pending result is back
   task automatic settle();
      if (req_if.valid === 1'b1) req_if.valid <= 1'b0;
      while (duty_expect.size() != 0) @(posedge clock);
   endtask

   // one request with random leading gaps; prediction made at acceptance
   task automatic send_tick(input tick_type tk, input bit typed, input drive_out_type want);
      drive_out_type guess;
      while (int'($urandom_range(99)) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.measured_speed <= tk.measured_speed;
      req_if.look_ahead     <= tk.look_ahead;
      req_if.on_ramp        <= tk.on_ramp;
      req_if.ramp_elapsed   <= tk.ramp_elapsed;
      req_if.in_turn        <= tk.in_turn;
      req_if.decel_restart  <= tk.decel_restart;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      advance_drive(tk, guess);
      duty_expect.push_back(typed ? want : guess);
      n_requests++;
   endtask

   // result side: check on each handshake, then pick the next ready
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_duty('{rsp_if.forward_duty, rsp_if.reverse_duty, rsp_if.target_now});
         rsp_if.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   // stimulus
   initial begin
      int ph;
      int k;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.measured_speed <= '0;
      req_if.look_ahead     <= '0;
      req_if.on_ramp        <= 1'b0;
      req_if.ramp_elapsed   <= '0;
      req_if.in_turn        <= 1'b0;
      req_if.decel_restart  <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      cfg_m     = CFG_RESET;
      tgt_speed = TARGET_RESET;
      prev_err  = '0;
      drive_acc = '0;
      decel_cnt = DECEL_MAX;
      build_plan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, settings changed only when idle
      foreach (tick_plan[i]) begin
         if (tick_plan[i].setting != cfg_m) begin
            settle();
            load_cfg(tick_plan[i].setting);
         end
         send_tick(tick_plan[i].tick, tick_plan[i].typed, tick_plan[i].want);
      end

      // random phases, each with its own setting and idle pattern
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         load_cfg(phase_cfg(ph));
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 54;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 54;
            end
            default: begin
               gap_pct   = 36;
               stall_pct = 36;
            end
         endcase
         for (k = 0; k < PHASE_TICKS; k++) begin
            // let the pipeline run dry once, in the middle of phase 5
            if (ph == 5 && k == PHASE_TICKS / 2) settle();
            send_tick(rand_tick(), 1'b0, '0);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d results for %0d requests over %0d settings (%0d register writes).",
               n_results, n_requests, n_settings, n_writes);
      $display("Idle patterns covered: none, sender gaps, receiver stalls, both; mismatches: %0d",
               n_mismatch);
      if (n_mismatch == 0 && duty_expect.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
